// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset
`define CHK_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock, quiet during reset
`define CHK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

// ===== hdl/bpag_pkg.sv =====
// Package: constants, tables, state type and control structs of the angle-gap block
package bpag_pkg;

   localparam int MAX_NEIGHBORS = 32;
   localparam int ANGLE_BITS    = 16;
   localparam int ADDR_W        = $clog2(MAX_NEIGHBORS);
   localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
   localparam int GAP_W         = ANGLE_BITS + 1;

   localparam int COORD_W  = 24;
   localparam int AXIS_W   = 18;
   localparam int THR_W    = 17;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = DIFF_W + AXIS_W;
   localparam int PROJ_W   = PROD_W + 1;
   localparam int CORD_W   = PROJ_W + 3;
   localparam int ACC_W    = 32;
   localparam int STEP_W   = 5;

   localparam int MUL_STEPS    = 6;
   localparam int CORDIC_STEPS = 28;
   localparam int NUM_REGS     = 7;

   localparam logic [2:0] REG_U_X = 3'd0;
   localparam logic [2:0] REG_U_Y = 3'd1;
   localparam logic [2:0] REG_U_Z = 3'd2;
   localparam logic [2:0] REG_V_X = 3'd3;
   localparam logic [2:0] REG_V_Y = 3'd4;
   localparam logic [2:0] REG_V_Z = 3'd5;
   localparam logic [2:0] REG_THR = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_PREP, ST_CORDIC, ST_ROUND, ST_INS_CHK, ST_INS_RD,
      ST_INS_CMP, ST_LAST_CHK, ST_SCAN_RD, ST_SCAN_CMP, ST_WRAP, ST_FIN
   } state_type;

   typedef struct packed {
      logic              load;
      logic              mul_en;
      logic              acc_en;
      logic [STEP_W-1:0] step;
      logic              cordic_init;
      logic              cordic_en;
      logic              round_en;
      logic              ins_start;
      logic              ins_rd;
      logic              ins_shift;
      logic              ins_put;
      logic              drop_set;
      logic              scan_start;
      logic              scan_rd;
      logic              scan_cmp;
      logic              wrap_en;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic proj_zero;
      logic count_full;
      logic pos_zero;
      logic rd_gt;
      logic last;
      logic scan_ok;
      logic scan_last;
      logic out_busy;
   } status_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [ACC_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
      logic [ACC_W-1:0] r;
      case (i)
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933406;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10679838;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335087;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41722;
         5'd15:   r = 32'd20861;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2608;
         5'd19:   r = 32'd1304;
         5'd20:   r = 32'd652;
         5'd21:   r = 32'd326;
         5'd22:   r = 32'd163;
         5'd23:   r = 32'd81;
         5'd24:   r = 32'd41;
         5'd25:   r = 32'd20;
         5'd26:   r = 32'd10;
         5'd27:   r = 32'd5;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/boundary_point_angle_gap.sv =====
// Top level: boundary point test by largest angular gap of neighbour offsets
//
// Feed a query set as a run of neighbour transactions on the req_ channel; the
// query point is taken from the first transaction of the set and last_nbr
// closes it. Each neighbour offset is projected onto the plane axes u and v
// with one shared 25x18 multiplier (six products, u then v), turned
// into a 16-bit fraction-of-a-turn angle by a 28-iteration CORDIC, and
// insertion-sorted into a 32-entry angle memory, moving one entry at a
// time past each stored angle that sits above it. A neighbour whose
// projection is zero on both axes skips the CORDIC and the insert. On
// the closing transaction the angles are scanned in order, and a single rsp_
// transaction carries the largest gap, the kept count and the overflow flag.
// Sets with fewer than three neighbours or no kept angle report a zero gap.
// A finished result waits in its own register, so a new set may start while
// the result is still held. Write the csr_ registers only while idle.
module boundary_point_angle_gap import bpag_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [2:0]                csr_addr,
   input  logic [AXIS_W-1:0]         csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_query_x,
   input  logic signed [COORD_W-1:0] req_query_y,
   input  logic signed [COORD_W-1:0] req_query_z,
   input  logic signed [COORD_W-1:0] req_nbr_x,
   input  logic signed [COORD_W-1:0] req_nbr_y,
   input  logic signed [COORD_W-1:0] req_nbr_z,
   input  logic                      req_last_nbr,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_is_boundary,
   output logic [GAP_W-1:0]          rsp_max_gap,
   output logic [CNT_W-1:0]          rsp_kept_count,
   output logic                      rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   // sequencer: one neighbour transaction at a time
   bpag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, angle memory and result register
   bpag_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_query_x     (req_query_x),
      .req_query_y     (req_query_y),
      .req_query_z     (req_query_z),
      .req_nbr_x       (req_nbr_x),
      .req_nbr_y       (req_nbr_y),
      .req_nbr_z       (req_nbr_z),
      .req_last_nbr    (req_last_nbr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_boundary (rsp_is_boundary),
      .rsp_max_gap     (rsp_max_gap),
      .rsp_kept_count  (rsp_kept_count),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

// ===== hdl/bpag_ctrl.sv =====
// Controller: sequences projection, CORDIC, sorted insert and gap scan
module bpag_ctrl import bpag_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      cmd.step  = step_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = (step_ff < STEP_W'(MUL_STEPS));
            cmd.acc_en = (step_ff != '0);
            if (step_ff == STEP_W'(MUL_STEPS)) begin
               step_in  = '0;
               state_in = ST_PREP;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PREP: begin
            if (status.proj_zero) begin
               state_in = ST_LAST_CHK;
            end else begin
               cmd.cordic_init = 1'b1;
               state_in        = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            cmd.cordic_en = 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_ROUND;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            state_in     = ST_INS_CHK;
         end
         ST_INS_CHK: begin
            if (status.count_full) begin
               cmd.drop_set = 1'b1;
               state_in     = ST_LAST_CHK;
            end else begin
               cmd.ins_start = 1'b1;
               state_in      = ST_INS_RD;
            end
         end
         ST_INS_RD: begin
            if (status.pos_zero) begin
               cmd.ins_put = 1'b1;
               state_in    = ST_LAST_CHK;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (status.rd_gt) begin
               cmd.ins_shift = 1'b1;
               state_in      = ST_INS_RD;
            end else begin
               cmd.ins_put = 1'b1;
               state_in    = ST_LAST_CHK;
            end
         end
         ST_LAST_CHK: begin
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.scan_ok) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = status.scan_last ? ST_WRAP : ST_SCAN_RD;
         end
         ST_WRAP: begin
            cmd.wrap_en = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/bpag_dp.sv =====
// Datapath: registers, projection multiplier, CORDIC, angle store and gap scan
module bpag_dp import bpag_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      csr_we,
   input  logic [2:0]                csr_addr,
   input  logic [AXIS_W-1:0]         csr_wdata,
   input  logic signed [COORD_W-1:0] req_query_x,
   input  logic signed [COORD_W-1:0] req_query_y,
   input  logic signed [COORD_W-1:0] req_query_z,
   input  logic signed [COORD_W-1:0] req_nbr_x,
   input  logic signed [COORD_W-1:0] req_nbr_y,
   input  logic signed [COORD_W-1:0] req_nbr_z,
   input  logic                      req_last_nbr,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_is_boundary,
   output logic [GAP_W-1:0]          rsp_max_gap,
   output logic [CNT_W-1:0]          rsp_kept_count,
   output logic                      rsp_overflow
);

   logic signed [AXIS_W-1:0]  axis_ff [MUL_STEPS];
   logic [THR_W-1:0]          thr_ff;
   logic signed [COORD_W-1:0] q_ff [3];
   logic signed [DIFF_W-1:0]  d_ff [3];
   logic [1:0]                seen_ff;
   logic                      last_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      drop_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROJ_W-1:0]  pu_ff, pv_ff;
   logic signed [CORD_W-1:0]  cx_ff, cy_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic [ANGLE_BITS-1:0]     angle_ff;
   logic [CNT_W-1:0]          pos_ff;
   logic [ANGLE_BITS-1:0]     mem [MAX_NEIGHBORS];
   logic [ANGLE_BITS-1:0]     rd_ff;
   logic [ADDR_W-1:0]         rd_addr;
   logic [ADDR_W-1:0]         idx_ff;
   logic [ANGLE_BITS-1:0]     first_ff, prev_ff;
   logic [GAP_W-1:0]          max_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_bnd_ff, rsp_ovf_ff;
   logic [GAP_W-1:0]          rsp_gap_ff;
   logic [CNT_W-1:0]          rsp_cnt_ff;

   logic signed [COORD_W-1:0] qsel [3];
   logic signed [COORD_W-1:0] nbr  [3];
   logic signed [DIFF_W-1:0]  d_sel;
   logic signed [AXIS_W-1:0]  a_sel;
   logic signed [PROD_W-1:0]  mul_w;
   logic signed [PROJ_W-1:0]  prod_ext;
   logic signed [CORD_W-1:0]  xs, ys;
   logic [ACC_W-1:0]          rnd_sum;
   logic [ANGLE_BITS-1:0]     diff_w;
   logic [GAP_W-1:0]          wrap_w;

   assign nbr[0]  = req_nbr_x;
   assign nbr[1]  = req_nbr_y;
   assign nbr[2]  = req_nbr_z;
   assign qsel[0] = (seen_ff == 2'd0) ? req_query_x : q_ff[0];
   assign qsel[1] = (seen_ff == 2'd0) ? req_query_y : q_ff[1];
   assign qsel[2] = (seen_ff == 2'd0) ? req_query_z : q_ff[2];

   // u products first, then v products
   always_comb begin
      case (cmd.step)
         5'd0, 5'd3: d_sel = d_ff[0];
         5'd1, 5'd4: d_sel = d_ff[1];
         5'd2, 5'd5: d_sel = d_ff[2];
         default:    d_sel = d_ff[0];
      endcase
      if (cmd.step < STEP_W'(MUL_STEPS)) a_sel = axis_ff[cmd.step[2:0]];
      else                                a_sel = axis_ff[0];
   end

   assign mul_w    = d_sel * a_sel;
   assign prod_ext = {{(PROJ_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign xs       = cx_ff >>> cmd.step;
   assign ys       = cy_ff >>> cmd.step;
   assign rnd_sum  = acc_ff + (ACC_W'(1) << (ACC_W - ANGLE_BITS - 1));
   assign rd_addr  = cmd.scan_rd ? idx_ff : ADDR_W'(pos_ff - 1'b1);
   assign diff_w   = rd_ff - prev_ff;
   assign wrap_w   = (GAP_W'(1) << ANGLE_BITS) - {1'b0, prev_ff} + {1'b0, first_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[0] <= AXIS_W'(65536);
         axis_ff[1] <= '0;
         axis_ff[2] <= '0;
         axis_ff[3] <= '0;
         axis_ff[4] <= AXIS_W'(65536);
         axis_ff[5] <= '0;
         thr_ff     <= THR_W'(16384);
      end else if (csr_we) begin
         case (csr_addr)
            REG_U_X: axis_ff[0] <= csr_wdata;
            REG_U_Y: axis_ff[1] <= csr_wdata;
            REG_U_Z: axis_ff[2] <= csr_wdata;
            REG_V_X: axis_ff[3] <= csr_wdata;
            REG_V_Y: axis_ff[4] <= csr_wdata;
            REG_V_Z: axis_ff[5] <= csr_wdata;
            REG_THR: thr_ff     <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // set state
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         q_ff[0]  <= '0;
         q_ff[1]  <= '0;
         q_ff[2]  <= '0;
      end else begin
         if (cmd.load) begin
            if (seen_ff != 2'd3) seen_ff <= seen_ff + 1'b1;
            q_ff[0] <= qsel[0];
            q_ff[1] <= qsel[1];
            q_ff[2] <= qsel[2];
         end
         if (cmd.ins_put)  count_ff <= count_ff + 1'b1;
         if (cmd.drop_set) drop_ff  <= 1'b1;
         if (cmd.out_load) begin
            seen_ff  <= '0;
            count_ff <= '0;
            drop_ff  <= 1'b0;
         end
      end
   end

   // arithmetic and scan registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < 3; k++) begin
            d_ff[k] <= DIFF_W'(nbr[k]) - DIFF_W'(qsel[k]);
         end
         last_ff <= req_last_nbr;
         pu_ff   <= '0;
         pv_ff   <= '0;
         max_ff  <= '0;
      end
      if (cmd.mul_en) prod_ff <= mul_w;
      if (cmd.acc_en) begin
         if (cmd.step <= STEP_W'(3)) pu_ff <= pu_ff + prod_ext;
         else                        pv_ff <= pv_ff + prod_ext;
      end
      if (cmd.cordic_init) begin
         if (pu_ff < 0) begin
            cx_ff  <= -CORD_W'(pu_ff);
            cy_ff  <= -CORD_W'(pv_ff);
            acc_ff <= 32'h8000_0000;
         end else begin
            cx_ff  <= CORD_W'(pu_ff);
            cy_ff  <= CORD_W'(pv_ff);
            acc_ff <= '0;
         end
      end
      if (cmd.cordic_en) begin
         if (cy_ff > 0) begin
            cx_ff  <= cx_ff + ys;
            cy_ff  <= cy_ff - xs;
            acc_ff <= acc_ff + atan_turn(cmd.step);
         end else begin
            cx_ff  <= cx_ff - ys;
            cy_ff  <= cy_ff + xs;
            acc_ff <= acc_ff - atan_turn(cmd.step);
         end
      end
      if (cmd.round_en)  angle_ff <= rnd_sum[ACC_W-1 -: ANGLE_BITS];
      if (cmd.ins_start) pos_ff   <= count_ff;
      if (cmd.ins_shift) pos_ff   <= pos_ff - 1'b1;
      if (cmd.scan_start) begin
         idx_ff <= '0;
         max_ff <= '0;
      end
      if (cmd.scan_cmp) begin
         if (idx_ff == '0) first_ff <= rd_ff;
         else if (GAP_W'(diff_w) > max_ff) max_ff <= GAP_W'(diff_w);
         prev_ff <= rd_ff;
         idx_ff  <= idx_ff + 1'b1;
      end
      if (cmd.wrap_en && (wrap_w > max_ff)) max_ff <= wrap_w;
   end

   // angle store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.ins_shift)    mem[pos_ff[ADDR_W-1:0]] <= rd_ff;
      else if (cmd.ins_put) mem[pos_ff[ADDR_W-1:0]] <= angle_ff;
      if (cmd.ins_rd || cmd.scan_rd) rd_ff <= mem[rd_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_bnd_ff <= (max_ff > thr_ff);
         rsp_gap_ff <= max_ff;
         rsp_cnt_ff <= count_ff;
         rsp_ovf_ff <= drop_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_boundary = rsp_bnd_ff;
   assign rsp_max_gap     = rsp_gap_ff;
   assign rsp_kept_count  = rsp_cnt_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   assign status.proj_zero  = (pu_ff == '0) && (pv_ff == '0);
   assign status.count_full = (count_ff == CNT_W'(MAX_NEIGHBORS));
   assign status.pos_zero   = (pos_ff == '0);
   assign status.rd_gt      = (rd_ff > angle_ff);
   assign status.last       = last_ff;
   assign status.scan_ok    = (seen_ff == 2'd3) && (count_ff != '0);
   assign status.scan_last  = (CNT_W'(idx_ff) + 1'b1 == count_ff);
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

endmodule

// ===== hdl/bpag_checker.sv =====
// Checker: port-level assertions on the angle-gap block, bound to the top level
`include "assert_macros.svh"

module bpag_checker import bpag_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_is_boundary,
   input logic [GAP_W-1:0] rsp_max_gap,
   input logic [CNT_W-1:0] rsp_kept_count,
   input logic             rsp_overflow
);

   `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `CHK_SAME(a_bnd_gap, rsp_valid && rsp_is_boundary, rsp_max_gap != '0)
   `CHK_SAME(a_cnt_max, rsp_valid, rsp_kept_count <= CNT_W'(MAX_NEIGHBORS))
   `CHK_SAME(a_ovf_full, rsp_valid && rsp_overflow, rsp_kept_count == CNT_W'(MAX_NEIGHBORS))

endmodule

bind boundary_point_angle_gap bpag_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_is_boundary (rsp_is_boundary),
   .rsp_max_gap     (rsp_max_gap),
   .rsp_kept_count  (rsp_kept_count),
   .rsp_overflow    (rsp_overflow)
);

// ===== tb/sv/boundary_point_angle_gap_test.sv =====
// Testbench for the angle-gap boundary test: directed sets, then random sets under several axes
`timescale 1ns / 1ps

module boundary_point_angle_gap_test import bpag_pkg::*;;

   localparam int CYCLE_LIMIT  = 1500000;
   localparam int SETTLE_WAIT  = 250;   // a little over the slowest neighbour plus a full scan
   localparam int PHASE_ITEMS  = 175;
   localparam int NUM_PHASES   = 6;
   localparam int HOLD_CYCLES  = 3000;
   localparam int FULL_TURN    = 1 << ANGLE_BITS;

   // arctangent of 2^-i, in units of 2^-32 turn
   localparam logic [31:0] ATAN_STEP [CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5
   };

   typedef struct {
      logic              bnd;
      logic [GAP_W-1:0]  gap;
      logic [CNT_W-1:0]  kept;
      logic              ovf;
   } gap_result_type;

   typedef struct {
      logic signed [COORD_W-1:0] qx, qy, qz, nx, ny, nz;
      logic                      last;
      logic                      known;
      logic                      bnd;
      logic [GAP_W-1:0]          gap;
      logic [CNT_W-1:0]          kept;
      logic                      ovf;
   } nbr_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_we    = 1'b0;
   logic [2:0]                csr_addr  = REG_U_X;
   logic [AXIS_W-1:0]         csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_query_x = '0, req_query_y = '0, req_query_z = '0;
   logic signed [COORD_W-1:0] req_nbr_x = '0, req_nbr_y = '0, req_nbr_z = '0;
   logic                      req_last_nbr = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_is_boundary;
   logic [GAP_W-1:0]          rsp_max_gap;
   logic [CNT_W-1:0]          rsp_kept_count;
   logic                      rsp_overflow;

   boundary_point_angle_gap u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Local copy of the plane axes, threshold and per-set state
   logic signed [AXIS_W-1:0] axis_u [3];
   logic signed [AXIS_W-1:0] axis_v [3];
   logic [THR_W-1:0]         gap_thr;
   logic [ANGLE_BITS-1:0]    sorted_angles [MAX_NEIGHBORS];
   int unsigned              stored_angles;
   int unsigned              set_members;
   longint                   query_pt [3];
   logic                     angles_dropped;

   gap_result_type gap_results_q [$];
   int             fail_count;
   int             items_sent;
   int             cycle_count;

   // Fraction-of-a-turn angle of (x, y) by vectoring CORDIC
   function automatic logic [ANGLE_BITS-1:0] angle_of(longint x, longint y);
      logic [31:0] acc;
      longint      xs, ys;
      logic [63:0] rounded;
      acc = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys;
            y -= xs;
            acc += ATAN_STEP[i];
         end else begin
            x -= ys;
            y += xs;
            acc -= ATAN_STEP[i];
         end
      end
      rounded = ({32'd0, acc} + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
      return rounded[ANGLE_BITS-1:0];
   endfunction

   // Advance the local copy by one accepted neighbour; return 1 with the result on a last one
   function automatic bit track_neighbour(nbr_row_type r, output gap_result_type res);
      longint           d [3];
      longint           pu, pv;
      logic [ANGLE_BITS-1:0] a;
      int unsigned      pos;
      longint           g, widest;
      pu = 0;
      pv = 0;
      if (set_members == 0) begin
         query_pt[0] = r.qx;
         query_pt[1] = r.qy;
         query_pt[2] = r.qz;
      end
      d[0] = longint'(r.nx) - query_pt[0];
      d[1] = longint'(r.ny) - query_pt[1];
      d[2] = longint'(r.nz) - query_pt[2];
      for (int k = 0; k < 3; k++) begin
         pu += d[k] * longint'(axis_u[k]);
         pv += d[k] * longint'(axis_v[k]);
      end
      if (set_members < 65535) set_members++;
      if (pu != 0 || pv != 0) begin
         a = angle_of(pu, pv);
         if (stored_angles >= MAX_NEIGHBORS) begin
            angles_dropped = 1'b1;
         end else begin
            // equal angles go after those already held
            pos = stored_angles;
            while (pos > 0 && sorted_angles[pos-1] > a) begin
               sorted_angles[pos] = sorted_angles[pos-1];
               pos--;
            end
            sorted_angles[pos] = a;
            stored_angles++;
         end
      end
      if (!r.last) return 0;
      widest = 0;
      if (set_members >= 3 && stored_angles > 0) begin
         for (int i = 0; i + 1 < stored_angles; i++) begin
            g = longint'(sorted_angles[i+1]) - longint'(sorted_angles[i]);
            if (g > widest) widest = g;
         end
         g = FULL_TURN - longint'(sorted_angles[stored_angles-1]) + longint'(sorted_angles[0]);
         if (g > widest) widest = g;
      end
      res.bnd  = widest > longint'(gap_thr);
      res.gap  = widest[GAP_W-1:0];
      res.kept = stored_angles[CNT_W-1:0];
      res.ovf  = angles_dropped;
      stored_angles  = 0;
      set_members    = 0;
      angles_dropped = 1'b0;
      return 1;
   endfunction

   // Offer one transaction after an idle gap; hold valid and payload until accepted
   task automatic send_neighbour(nbr_row_type r, int gap);
      gap_result_type res;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_query_x  <= r.qx;
      req_query_y  <= r.qy;
      req_query_z  <= r.qz;
      req_nbr_x    <= r.nx;
      req_nbr_y    <= r.ny;
      req_nbr_z    <= r.nz;
      req_last_nbr <= r.last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (track_neighbour(r, res)) begin
         if (r.known) begin
            res.bnd  = r.bnd;
            res.gap  = r.gap;
            res.kept = r.kept;
            res.ovf  = r.ovf;
         end
         gap_results_q = {gap_results_q, res};
      end
   endtask

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 19);
      if (quiet || r < 11) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Drop valid, wait for every expected result, then let the block settle before a write
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (gap_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_axes(logic signed [AXIS_W-1:0] u [3], logic signed [AXIS_W-1:0] v [3],
                             logic [THR_W-1:0] thr);
      for (int k = 0; k < 3; k++) begin
         csr_we    <= 1'b1;
         csr_addr  <= REG_U_X + 3'(k);
         csr_wdata <= u[k];
         axis_u[k]  = u[k];
         @(posedge clock);
         csr_addr  <= REG_V_X + 3'(k);
         csr_wdata <= v[k];
         axis_v[k]  = v[k];
         @(posedge clock);
      end
      csr_addr  <= REG_THR;
      csr_wdata <= {1'b0, thr};
      gap_thr    = thr;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [COORD_W-1:0] near(logic signed [COORD_W-1:0] c, int span);
      return c + COORD_W'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // One random query set: mostly points around the query, with some exact repeats,
   // zero offsets and wild points mixed in
   task automatic random_set();
      nbr_row_type r, prev;
      int          size, span, sel;
      bit          quiet;
      sel = $urandom_range(0, 19);
      if (sel == 0)      size = $urandom_range(1, 2);
      else if (sel == 1) size = $urandom_range(MAX_NEIGHBORS + 1, MAX_NEIGHBORS + 8);
      else               size = $urandom_range(3, 14);
      case ($urandom_range(0, 2))
         0:       span = 16;
         1:       span = 4096;
         default: span = 1 << 20;
      endcase
      quiet  = ($urandom_range(0, 3) == 0);
      r      = '{default: '0};
      r.qx   = COORD_W'($urandom);
      r.qy   = COORD_W'($urandom);
      r.qz   = COORD_W'($urandom);
      prev   = r;
      for (int i = 0; i < size; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               r.nx = r.qx; r.ny = r.qy; r.nz = r.qz;
            end
            1: begin
               r.nx = COORD_W'($urandom); r.ny = COORD_W'($urandom); r.nz = COORD_W'($urandom);
            end
            2: begin
               r.nx = prev.nx; r.ny = prev.ny; r.nz = prev.nz;
            end
            default: begin
               r.nx = near(r.qx, span); r.ny = near(r.qy, span); r.nz = near(r.qz, span);
            end
         endcase
         r.last = (i == size - 1);
         prev   = r;
         send_neighbour(r, pick_gap(quiet));
      end
   endtask

   // Result side: random stalls, quiet stretches, and one long hold-off to back up the input
   initial begin : result_side
      int             stall_left;
      int             quiet_left;
      bit             held;
      gap_result_type want;
      stall_left = 0;
      quiet_left = 0;
      held       = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (gap_results_q.size() == 0) begin
               $error("result with nothing expected");
               fail_count++;
            end else begin
               want = gap_results_q.pop_front();
               if (rsp_is_boundary !== want.bnd) begin
                  $error("is_boundary: expected %0d, got %0d", want.bnd, rsp_is_boundary);
                  fail_count++;
               end
               if (rsp_max_gap !== want.gap) begin
                  $error("max_gap: expected %0d, got %0d", want.gap, rsp_max_gap);
                  fail_count++;
               end
               if (rsp_kept_count !== want.kept) begin
                  $error("kept_count: expected %0d, got %0d", want.kept, rsp_kept_count);
                  fail_count++;
               end
               if (rsp_overflow !== want.ovf) begin
                  $error("overflow: expected %0d, got %0d", want.ovf, rsp_overflow);
                  fail_count++;
               end
            end
         end
         if (!held && items_sent >= 300) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (quiet_left > 0) quiet_left--;
         else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(100, 400);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (quiet_left == 0) begin
               case ($urandom_range(0, 29))
                  0, 1, 2, 3, 4, 5: stall_left = $urandom_range(1, 3);
                  6:                stall_left = $urandom_range(20, 120);
                  default:          stall_left = 0;
               endcase
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      nbr_row_type              dir_rows [19];
      logic signed [AXIS_W-1:0] u [3];
      logic signed [AXIS_W-1:0] v [3];
      logic [THR_W-1:0]         thr;
      int                       phase_start;
      fail_count     = 0;
      items_sent     = 0;
      cycle_count    = 0;
      stored_angles  = 0;
      set_members    = 0;
      angles_dropped = 1'b0;
      query_pt       = '{0, 0, 0};
      axis_u         = '{18'sd65536, 18'sd0, 18'sd0};
      axis_v         = '{18'sd0, 18'sd65536, 18'sd0};
      gap_thr        = 17'd16384;

      // qx qy qz  nx ny nz  last  known bnd gap kept ovf
      dir_rows[0]  = '{0, 0, 0, 4096, 0, 0, 1, 1, 0, 0, 1, 0};           // lone neighbour
      dir_rows[1]  = '{100, 100, 100, 100, 100, 100, 0, 0, 0, 0, 0, 0};  // all offsets zero
      dir_rows[2]  = '{0, 0, 0, 100, 100, 100, 0, 0, 0, 0, 0, 0};
      dir_rows[3]  = '{0, 0, 0, 100, 100, 100, 1, 1, 0, 0, 0, 0};
      dir_rows[4]  = '{0, 0, 0, 4096, 0, 0, 0, 0, 0, 0, 0, 0};           // four compass points
      dir_rows[5]  = '{0, 0, 0, 0, 4096, 0, 0, 0, 0, 0, 0, 0};
      dir_rows[6]  = '{0, 0, 0, -4096, 0, 0, 0, 0, 0, 0, 0, 0};
      dir_rows[7]  = '{0, 0, 0, 0, -4096, 0, 1, 0, 0, 0, 0, 0};
      dir_rows[8]  = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,               // coordinate extremes
                       24'h800000, 24'h800000, 24'h800000, 0, 0, 0, 0, 0, 0};
      dir_rows[9]  = '{0, 0, 0, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0, 0, 0};
      dir_rows[10] = '{0, 0, 0, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1, 0, 0, 0, 0, 0};
      dir_rows[11] = '{0, 0, 0, 4096, 1, 0, 0, 0, 0, 0, 0, 0};           // tight cluster
      dir_rows[12] = '{0, 0, 0, 4096, 2, 0, 0, 0, 0, 0, 0, 0};
      dir_rows[13] = '{0, 0, 0, 4096, 3, 0, 1, 0, 0, 0, 0, 0};
      dir_rows[14] = '{0, 0, 0, 4096, 4096, 0, 0, 0, 0, 0, 0, 0};        // repeated angles
      dir_rows[15] = '{0, 0, 0, 8192, 8192, 0, 0, 0, 0, 0, 0, 0};
      dir_rows[16] = '{0, 0, 0, 4096, 4096, 0, 1, 0, 0, 0, 0, 0};
      dir_rows[17] = '{0, 0, 0, 0, 4096, 0, 0, 0, 0, 0, 0, 0};           // two neighbours only
      dir_rows[18] = '{0, 0, 0, 4096, 0, 0, 1, 1, 0, 0, 2, 0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_neighbour(dir_rows[i], pick_gap(1'b0));

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_and_settle();
         case (phase)
            0: begin  // reset axes written back explicitly, threshold at its floor
               u = '{18'sd65536, 18'sd0, 18'sd0};
               v = '{18'sd0, 18'sd65536, 18'sd0};
               thr = '0;
            end
            1: begin  // negative axis values, threshold at a full turn
               u = '{-18'sd65536, -18'sd65536, -18'sd65536};
               v = '{18'sd0, 18'sd0, -18'sd65536};
               thr = 17'(FULL_TURN);
            end
            2: begin
               u = '{18'sd65536, 18'sd65536, 18'sd65536};
               v = '{-18'sd65536, 18'sd65536, -18'sd1};
               thr = 17'd16384;
            end
            default: begin
               for (int k = 0; k < 3; k++) begin
                  u[k] = AXIS_W'($urandom_range(0, 131072) - 65536);
                  v[k] = AXIS_W'($urandom_range(0, 131072) - 65536);
               end
               thr = 17'($urandom_range(0, FULL_TURN));
            end
         endcase
         write_axes(u, v, thr);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) random_set();
      end
      req_valid <= 1'b0;

      while (gap_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0 && gap_results_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bpag_pkg.sv
hdl/bpag_ctrl.sv
hdl/bpag_dp.sv
hdl/boundary_point_angle_gap.sv
hdl/bpag_checker.sv
tb/sv/boundary_point_angle_gap_test.sv
